### hw/rtl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg: shared definitions for the sine series block
// Widths, the term cap, the divider cell record and the divisor function.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int MAX_TERMS = 16;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);

  localparam int DEN_W     = 13;   // (2k+2)(2k+3) for k up to 31
  localparam int DVD_W     = 56;   // 52-bit product slice padded to whole cells
  localparam int CELL_BITS = 8;
  localparam int N_CELLS   = DVD_W / CELL_BITS;

  // one word travelling down the divider chain
  typedef struct packed {
    logic             vld;
    logic [DEN_W-1:0] rem;
    logic [DVD_W-1:0] acc;   // dividend in, quotient out
    logic [DEN_W-1:0] den;
  } sts_div_t;

  function automatic logic [DEN_W-1:0] den_of(input logic [4:0] k);
    logic [6:0] a;
    logic [6:0] b;
    a = {1'b0, k, 1'b0} + 7'd2;
    b = a + 7'd1;
    return DEN_W'(14'(a) * 14'(b));
  endfunction

endpackage

### hw/rtl/sts_div_cell.sv
// ----------------------------------------------------------------------------
// sts_div_cell: one cell of the divider chain
// Retires CELL_BITS restoring quotient bits per cycle and passes the word on.
// ----------------------------------------------------------------------------
module sts_div_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  sts_pkg::sts_div_t d_in,
  output sts_pkg::sts_div_t d_out
);
  import sts_pkg::*;

  sts_div_t   stp;
  sts_div_t   d_out_r;
  logic [DEN_W:0] r_wide;

  always_comb begin
    stp    = d_in;
    r_wide = '0;
    for (int i = 0; i < CELL_BITS; i++) begin
      r_wide  = {stp.rem, stp.acc[DVD_W-1]};
      stp.acc = {stp.acc[DVD_W-2:0], 1'b0};
      if (r_wide >= {1'b0, stp.den}) begin
        r_wide     = r_wide - {1'b0, stp.den};
        stp.acc[0] = 1'b1;
      end
      stp.rem = r_wide[DEN_W-1:0];
    end
  end

  // only the valid bit is reset; the data fields follow it unconditionally
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_out_r.vld <= 1'b0;
    end else begin
      d_out_r.vld <= d_in.vld;
    end
    d_out_r.rem <= stp.rem;
    d_out_r.acc <= stp.acc;
    d_out_r.den <= stp.den;
  end

  assign d_out = d_out_r;

endmodule

### hw/rtl/sts_div_chain.sv
// ----------------------------------------------------------------------------
// sts_div_chain: row of divider cells
// Unsigned DVD_W-bit by DEN_W-bit division through a row of registered cells.
// ----------------------------------------------------------------------------
module sts_div_chain (
  input  logic              clk,
  input  logic              rst_n,
  input  sts_pkg::sts_div_t d_in,
  output sts_pkg::sts_div_t d_out
);
  import sts_pkg::*;

  sts_div_t link [N_CELLS+1];

  assign link[0] = d_in;

  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    sts_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (link[g]),
      .d_out (link[g+1])
    );
  end

  assign d_out = link[N_CELLS];

endmodule

### hw/rtl/sine_taylor_series_eps.sv
// ----------------------------------------------------------------------------
// sine_taylor_series_eps: sine by Maclaurin series with epsilon stop
// Sums x - x^3/3! + ... in Q8.39 until a term falls to epsilon or the cap.
// ----------------------------------------------------------------------------
// One angle (signed Q2.29) is taken when start is high and busy is low; the
// result word appears on the out_ ports for a single cycle with out_valid and
// cannot be held off. A run first squares the angle, then for each of the n
// terms summed (0 to MAX_TERMS) it does a check, a pass over the shared
// 32x32 multiplier (four partial products of term times x^2), a launch and a
// wait on the divider chain that divides by (2k+2)(2k+3). A last check ends
// the run, and the result word is registered from S_FIN. busy
// stays high for the whole run. The epsilon register is written through the
// cfg_ channel, which is always ready; write it only while busy is low.
module sine_taylor_series_eps (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_angle,
  output logic        out_valid,
  output logic [31:0] out_sine_value,
  output logic [4:0]  out_terms_used,
  output logic        out_limit_hit,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_eps_threshold
);
  import sts_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SQ   = 8'b0000_0010,
    S_SQW  = 8'b0000_0100,
    S_CHK  = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_DIVL = 8'b0010_0000,
    S_DIVW = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  localparam int ACC_W = 91;

  state_t             state_r, state_nxt;
  logic [30:0]        eps_r;
  logic               neg_r, neg_nxt;
  logic [31:0]        amag_r, amag_nxt;
  logic [43:0]        x2_r, x2_nxt;
  logic [46:0]        mag_r, mag_nxt;
  logic signed [47:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [2:0]         ph_r, ph_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic               limit_r, limit_nxt;
  logic [63:0]        prod_r;
  logic [31:0]        op_a, op_b;

  logic               out_valid_r;
  logic [31:0]        out_sine_r;
  logic [4:0]         out_terms_r;
  logic               out_limit_r;

  sts_div_t           div_in, div_out;

  // saturating add and output rounding
  logic signed [48:0] add_t;
  logic signed [48:0] rnd_t;
  logic [38:0]        rnd_q;
  logic [31:0]        sine_sat;
  logic [5:0]         cnt6;
  logic [46:0]        eps_ext;
  logic [46:0]        quo_sat;

  assign eps_ext = {6'b0, eps_r, 10'b0};

  always_comb begin
    if (neg_r) begin
      add_t = {sum_r[47], sum_r} - $signed({2'b00, mag_r});
    end else begin
      add_t = {sum_r[47], sum_r} + $signed({2'b00, mag_r});
    end
  end

  always_comb begin
    rnd_t = {sum_r[47], sum_r} + 49'sd512;
    rnd_q = rnd_t[48:10];                     // floor division by 1024
    if (!rnd_q[38] && (|rnd_q[38:31])) begin
      sine_sat = 32'h7FFF_FFFF;
    end else if (rnd_q[38] && !(&rnd_q[38:31])) begin
      sine_sat = 32'h8000_0000;
    end else begin
      sine_sat = rnd_q[31:0];
    end
  end

  assign cnt6    = 6'(cnt_r);
  assign quo_sat = (|div_out.acc[DVD_W-1:47]) ? {47{1'b1}} : div_out.acc[46:0];

  // shared multiplier: angle square, then four partials of term * x^2
  always_comb begin
    op_a = amag_r;
    op_b = amag_r;
    if (state_r == S_MUL) begin
      case (ph_r)
        3'd0:    begin op_a = mag_r[31:0];          op_b = x2_r[31:0];          end
        3'd1:    begin op_a = mag_r[31:0];          op_b = {20'b0, x2_r[43:32]}; end
        3'd2:    begin op_a = {17'b0, mag_r[46:32]}; op_b = x2_r[31:0];          end
        default: begin op_a = {17'b0, mag_r[46:32]}; op_b = {20'b0, x2_r[43:32]}; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(op_a) * 64'(op_b);
  end

  always_comb begin
    state_nxt = state_r;
    neg_nxt   = neg_r;
    amag_nxt  = amag_r;
    x2_nxt    = x2_r;
    mag_nxt   = mag_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    ph_nxt    = ph_r;
    acc_nxt   = acc_r;
    limit_nxt = limit_r;
    div_in    = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          neg_nxt   = in_angle[31];
          amag_nxt  = in_angle[31] ? (32'd0 - in_angle) : in_angle;
          sum_nxt   = '0;
          cnt_nxt   = '0;
          limit_nxt = 1'b0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        state_nxt = S_SQW;
      end
      S_SQW: begin
        x2_nxt    = prod_r[62:19];
        mag_nxt   = {5'b0, amag_r, 10'b0};
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (mag_r <= eps_ext) begin
          state_nxt = S_FIN;
        end else if (cnt_r >= CNT_W'(MAX_TERMS)) begin
          limit_nxt = 1'b1;
          state_nxt = S_FIN;
        end else begin
          if (add_t[48:47] == 2'b01) begin
            sum_nxt = 48'sh7FFF_FFFF_FFFF;
          end else if (add_t[48:47] == 2'b10) begin
            sum_nxt = 48'sh8000_0000_0000;
          end else begin
            sum_nxt = add_t[47:0];
          end
          cnt_nxt   = cnt_r + 1'b1;
          ph_nxt    = '0;
          acc_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // fold in the partial issued last cycle
        case (ph_r)
          3'd1:    acc_nxt = acc_r + ACC_W'(prod_r);
          3'd2:    acc_nxt = acc_r + (ACC_W'(prod_r) << 32);
          3'd3:    acc_nxt = acc_r + (ACC_W'(prod_r) << 32);
          3'd4:    acc_nxt = acc_r + (ACC_W'(prod_r) << 64);
          default: acc_nxt = acc_r;
        endcase
        ph_nxt = ph_r + 3'd1;
        if (ph_r == 3'd4) begin
          state_nxt = S_DIVL;
        end
      end
      S_DIVL: begin
        div_in.vld = 1'b1;
        div_in.rem = '0;
        div_in.acc = {4'b0, acc_r[90:39]};
        div_in.den = den_of(5'(cnt_r - 1'b1));
        state_nxt  = S_DIVW;
      end
      S_DIVW: begin
        if (div_out.vld) begin
          mag_nxt   = quo_sat;
          neg_nxt   = ~neg_r;
          state_nxt = S_CHK;
        end
      end
      S_FIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  sts_div_chain u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .d_in  (div_in),
    .d_out (div_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      eps_r       <= 31'd537;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_FIN);
      if (cfg_valid && cfg_ready) begin
        eps_r <= cfg_eps_threshold;
      end
    end
  end

  always_ff @(posedge clk) begin
    neg_r   <= neg_nxt;
    amag_r  <= amag_nxt;
    x2_r    <= x2_nxt;
    mag_r   <= mag_nxt;
    sum_r   <= sum_nxt;
    cnt_r   <= cnt_nxt;
    ph_r    <= ph_nxt;
    acc_r   <= acc_nxt;
    limit_r <= limit_nxt;
    if (state_r == S_FIN) begin
      out_sine_r  <= sine_sat;
      out_terms_r <= cnt6[5] ? 5'd31 : cnt6[4:0];
      out_limit_r <= limit_r;
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_sine_value = out_sine_r;
  assign out_terms_used = out_terms_r;
  assign out_limit_hit  = out_limit_r;

`ifndef SYNTHESIS
  // a result word is a single-cycle strobe
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held for more than one cycle");

  // an accepted angle makes the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after start");

  // the cap only fires once the full term count is reached
  a_limit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_limit_hit) |-> (out_terms_used == 5'(MAX_TERMS)))
    else $error("limit_hit with wrong term count");
`endif

endmodule

### dv/tb_sine_taylor_series_eps.sv
// ----------------------------------------------------------------------------
// tb_sine_taylor_series_eps: self-checking bench for the sine series block
// Sends angle words over the start/busy port, predicts each series sum,
// term count and cap flag, and checks every strobed result word in order.
// ----------------------------------------------------------------------------
module tb_sine_taylor_series_eps;
  import sts_pkg::*;

  localparam int RUN_MAX  = 14 * MAX_TERMS + 4;  // longest run, cycles
  localparam int WDOG_MAX = 20 * RUN_MAX;        // quiet cycles before abort

  localparam logic [31:0] ONE_Q29  = 32'h2000_0000;
  localparam logic [31:0] HALFPI   = 32'd843314857;
  localparam logic [30:0] EPS_RST  = 31'd537;
  localparam logic [30:0] EPS_MAX  = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [31:0] sine_value;
    logic [4:0]  terms_used;
    logic        limit_hit;
  } sine_word_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_angle;
  logic        out_valid;
  logic [31:0] out_sine_value;
  logic [4:0]  out_terms_used;
  logic        out_limit_hit;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [30:0] cfg_eps_threshold;

  sine_taylor_series_eps dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_angle          (in_angle),
    .out_valid         (out_valid),
    .out_sine_value    (out_sine_value),
    .out_terms_used    (out_terms_used),
    .out_limit_hit     (out_limit_hit),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_eps_threshold (cfg_eps_threshold)
  );

  // clock: 6 high, 6 low
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sine_word_t  sine_q[$];      // predicted result words, oldest first
  logic [30:0] eps_model;      // our copy of the epsilon register
  int          n_fail;
  int          quiet_cycles;
  int          burst_left;

  // --------------------------------------------------------------------------
  // Series predictor. Term kept as sign + magnitude in Q8.39, sum saturated
  // after every add, result rounded half up then clamped to 32 bits.
  // --------------------------------------------------------------------------
  function automatic sine_word_t sine_series(input logic [31:0] ang,
                                             input logic [30:0] eps_r);
    logic               neg;
    logic [32:0]        amag;
    logic [63:0]        x2, eps, mag, p, d;
    logic [127:0]       prod;
    logic signed [63:0] sum, v, r;
    int                 cnt, k;
    logic               lim;
    sine_word_t         w;
    neg  = ang[31];
    amag = neg ? (33'h1_0000_0000 - {1'b0, ang}) : {1'b0, ang};
    x2   = (64'(amag) * 64'(amag)) >> 19;
    eps  = 64'(eps_r) << 10;
    mag  = 64'(amag) << 10;
    if (mag > 64'h7FFF_FFFF_FFFF) mag = 64'h7FFF_FFFF_FFFF;
    sum = 0; cnt = 0; k = 0; lim = 1'b0;
    while (mag > eps) begin
      if (cnt >= MAX_TERMS) begin
        lim = 1'b1;
        break;
      end
      sum = neg ? sum - $signed(mag) : sum + $signed(mag);
      if (sum > 64'sh7FFF_FFFF_FFFF) sum = 64'sh7FFF_FFFF_FFFF;
      if (sum < -64'sh8000_0000_0000) sum = -64'sh8000_0000_0000;
      cnt++;
      d    = 64'((2 * k + 2) * (2 * k + 3));
      prod = 128'(mag) * 128'(x2);
      p    = (prod[127:103] != 0) ? '1 : prod[102:39];
      p    = p / d;
      mag  = (p > 64'h7FFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF : p;
      neg  = !neg;
      k++;
    end
    v = sum + 512;
    r = v >>> 10;                       // floor, matches the round half up
    if (r > 64'sh7FFF_FFFF) r = 64'sh7FFF_FFFF;
    if (r < -64'sh8000_0000) r = -64'sh8000_0000;
    w.sine_value = r[31:0];
    w.terms_used = (cnt > 31) ? 5'd31 : 5'(cnt);
    w.limit_hit  = lim;
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Drive one angle word; start stays up between words of a burst.
  // Prediction is queued on the accepting edge.
  // --------------------------------------------------------------------------
  task automatic send_angle(input logic [31:0] ang);
    start    <= 1'b1;
    in_angle <= ang;
    do @(posedge clk); while (busy);
    sine_q.push_back(sine_series(ang, eps_model));
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
  endtask

  // write epsilon only once the block has drained
  task automatic write_eps(input logic [30:0] val);
    start <= 1'b0;
    while (sine_q.size() != 0 || busy) @(posedge clk);
    cfg_valid         <= 1'b1;
    cfg_eps_threshold <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    eps_model = val;
  endtask

  // angles biased toward interesting regions: tiny, around +-1, randomly scaled down, full range
  function automatic logic [31:0] rand_angle();
    logic [31:0] a;
    case ($urandom_range(0, 5))
      0:       a = $urandom_range(0, 4096);
      1:       a = ONE_Q29 + $urandom_range(0, 65535) - 32768;
      2:       a = $urandom >> $urandom_range(0, 31);
      default: a = $urandom;
    endcase
    if ($urandom_range(0, 1)) a = -a;
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    logic [31:0] pats[$];
    pats = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
             ONE_Q29, -ONE_Q29, HALFPI, -HALFPI, 32'h0000_0219,
             32'h0000_021A, 32'h4000_0000, 32'hC000_0000, 32'h5555_5555,
             32'hAAAA_AAAA, 32'h6487_ED51};
    foreach (pats[i]) send_angle(pats[i]);
  endtask

  // zero epsilon: runs until a term truncates to 0 or the cap stops it
  task automatic test_zero_eps();
    write_eps(31'd0);
    send_angle(32'h0);
    send_angle(32'h7FFF_FFFF);
    send_angle(32'h8000_0000);
    send_angle(ONE_Q29);
    send_angle(32'h1);
  endtask

  // widest epsilon: only the full-scale negative angle produces any terms
  task automatic test_max_eps();
    write_eps(EPS_MAX);
    send_angle(32'h7FFF_FFFF);
    send_angle(32'h8000_0000);
    send_angle(ONE_Q29);
  endtask

  task automatic test_random(input int n_items);
    logic [30:0] e;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 5)
        0:       e = EPS_RST;
        1:       e = 31'd0;
        2:       e = 31'($urandom_range(0, 255));
        3:       e = 31'($urandom >> $urandom_range(1, 31));
        default: e = EPS_MAX >> $urandom_range(0, 12);
      endcase
      write_eps(e);
      for (int i = 0; i < n_items / 10; i++) send_angle(rand_angle());
    end
    write_eps(EPS_RST);
    for (int i = 0; i < 20; i++) send_angle(rand_angle());
  endtask

  // --------------------------------------------------------------------------
  // Result checker: every strobe pops the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (sine_q.size() == 0) begin
        $error("result word with nothing expected");
        n_fail++;
      end else begin
        sine_word_t w;
        w = sine_q.pop_front();
        if (out_sine_value !== w.sine_value) begin
          $error("sine_value expected %h got %h", w.sine_value, out_sine_value);
          n_fail++;
        end
        if (out_terms_used !== w.terms_used) begin
          $error("terms_used expected %0d got %0d", w.terms_used, out_terms_used);
          n_fail++;
        end
        if (out_limit_hit !== w.limit_hit) begin
          $error("limit_hit expected %b got %b", w.limit_hit, out_limit_hit);
          n_fail++;
        end
      end
    end
  end

  // watchdog: abort after too long with no word moving either way
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    start             <= 1'b0;
    in_angle          <= '0;
    cfg_valid         <= 1'b0;
    cfg_eps_threshold <= '0;
    rst_n             <= 1'b0;
    burst_left   = 4;
    eps_model    = EPS_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();         // reset epsilon
    test_zero_eps();
    test_max_eps();
    write_eps(31'd1);
    test_directed();
    test_random(1500);

    start <= 1'b0;
    while (sine_q.size() != 0) @(posedge clk);
    repeat (RUN_MAX) @(posedge clk);
    if (n_fail == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
